FILE: rtl/fms_pkg.sv
`timescale 1ns / 1ps
package fms_pkg;
	localparam int unsigned MaxSteps     = 1024;
	localparam int unsigned MinGrowSteps = 5;

	typedef enum logic [2:0] {
		REG_RMS_TARGET  = 3'd0,
		REG_START_DT    = 3'd1,
		REG_MAX_DT      = 3'd2,
		REG_START_MIX   = 3'd3,
		REG_GROW        = 3'd4,
		REG_SHRINK      = 3'd5,
		REG_MIX_DECAY   = 3'd6,
		REG_MAX_DISP    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CONTINUE  = 2'd0,
		ST_CONVERGED = 2'd1,
		ST_LIMIT     = 2'd2
	} status_t;

	// request to the shared sqrt/divide unit
	typedef struct packed {
		logic         sqrt_go;
		logic         div_go;
		logic [67:0]  radicand;
		logic [65:0]  dividend;
		logic [33:0]  divisor;
	} alu_req_t;

	typedef struct packed {
		logic         busy;
		logic [33:0]  root;
		logic [65:0]  quot;
	} alu_rsp_t;
endpackage

FILE: rtl/fms_iter.sv
`timescale 1ns / 1ps
// bit-serial square root (34-bit root of 68-bit radicand) and restoring divide
module fms_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  fms_pkg::alu_req_t  req,
	output fms_pkg::alu_rsp_t  rsp
);
	logic [6:0]  cnt_q;
	logic        mode_q;
	logic [67:0] rad_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [65:0] quot_q;
	logic [34:0] drem_q;
	logic [33:0] dvs_q;
	logic [35:0] trial;
	logic [35:0] rem_sh;
	logic [34:0] drem_sh;

	assign rem_sh  = {rem_q[33:0], rad_q[67:66]};
	assign trial   = {root_q, 2'b01};
	assign drem_sh = {drem_q[33:0], quot_q[65]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end else if (req.sqrt_go) begin
			cnt_q <= 7'd34;
			mode_q <= 1'b0;
		end else if (req.div_go) begin
			cnt_q <= 7'd66;
			mode_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == '0) begin
			if (req.sqrt_go) begin
				rad_q <= req.radicand;
				rem_q <= '0;
				root_q <= '0;
			end else if (req.div_go) begin
				quot_q <= req.dividend;
				drem_q <= '0;
				dvs_q <= req.divisor;
			end
		end else if (!mode_q) begin
			rad_q <= {rad_q[65:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[32:0], 1'b0};
			end
		end else begin
			if (drem_sh >= {1'b0, dvs_q}) begin
				drem_q <= drem_sh - {1'b0, dvs_q};
				quot_q <= {quot_q[64:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				quot_q <= {quot_q[64:0], 1'b0};
			end
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.root = root_q;
	assign rsp.quot = quot_q;
endmodule

FILE: rtl/fire_minimizer_step_top.sv
`timescale 1ns / 1ps
// One step of a fixed-point FIRE minimiser over a 6-component gradient. Each input beat
// carries the gradient and a start flag in tuser; each output beat carries the displacement,
// the rms gradient, a status and the step count. The work runs through one 34x34
// multiplier and one bit-serial sqrt/divide unit under a small sequencer: a bitwise
// search for the rms value on the multiplier, up to three square roots and up to twelve
// divides (six for the velocity mix, six more when the displacement is clamped). The
// block takes no new beat until the result beat has left. Configuration is written
// through cfg_we/cfg_addr/cfg_data; the user must write it only while idle, and the
// block itself does not enforce this.
module fire_minimizer_step_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [191:0]  s_axis_tdata,  // grad_0 .. grad_5
	input  logic          s_axis_tuser,  // start_req
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [239:0]  m_axis_tdata,  // disp_0..disp_5, rms_value, steps_taken, 5 zeros
	output logic [1:0]    m_axis_tuser,  // status
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE, S_SQ, S_GN, S_RMS, S_RMS_W, S_DECIDE, S_PW, S_PW_D, S_VN, S_VN_W,
		S_MIXT, S_MIX1, S_MIX2, S_MIX4, S_MIX5, S_ND, S_ND_W, S_CL, S_CL_W, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] rms_target_q, max_disp_q;
	logic [23:0] start_dt_q, max_dt_q, dt_q;
	logic [15:0] start_mix_q, shrink_q, decay_q, mix_q, sss_q;
	logic [17:0] grow_q;
	logic [10:0] run_q;
	logic        running_q, start_q;
	logic [31:0] vel_q [6];
	logic [31:0] g_q [6];
	logic [31:0] dx_q [6];
	logic [31:0] vn_q, rms_q, t_q;
	logic [33:0] gn_q, nd_q;
	logic [67:0] acc_q, neg_q;
	logic [2:0]  idx_q;
	logic [1:0]  sub_q;
	logic [4:0]  bit_q;
	logic [1:0]  status_q;
	logic [63:0] w_q;

	// shared multiplier
	logic [33:0] ma, mb;
	logic [67:0] mp;
	assign mp = ma * mb;

	// rms search: largest r with 6*r*r <= sum of squares
	logic [31:0] cand;
	logic [67:0] six_sq;
	assign cand   = rms_q | (32'd1 << bit_q);
	assign six_sq = {mp[65:0], 2'b00} + {mp[66:0], 1'b0};

	fms_pkg::alu_req_t req;
	fms_pkg::alu_rsp_t rsp;
	fms_iter u_iter (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	function automatic logic [31:0] mag32(input logic [31:0] x);
		mag32 = x[31] ? (~x + 32'd1) : x;
	endfunction
	function automatic logic [31:0] sat32(input logic signed [41:0] x);
		if (x > 42'sd2147483647) sat32 = 32'h7fffffff;
		else if (x < -42'sd2147483648) sat32 = 32'h80000000;
		else sat32 = x[31:0];
	endfunction

	logic [31:0] gi, vi, dxi;
	assign gi  = g_q[idx_q];
	assign vi  = vel_q[idx_q];
	assign dxi = dx_q[idx_q];

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SQ:   begin ma = {2'b0, mag32(gi)}; mb = {2'b0, mag32(gi)}; end
			S_RMS:  begin ma = {2'b0, cand}; mb = {2'b0, cand}; end
			S_PW:   begin ma = {2'b0, mag32(vi)}; mb = {2'b0, mag32(gi)}; end
			S_VN:   begin ma = {2'b0, mag32(vi)}; mb = {2'b0, mag32(vi)}; end
			S_ND:   begin ma = {2'b0, mag32(dxi)}; mb = {2'b0, mag32(dxi)}; end
			S_DECIDE: begin
				case (sub_q)
					2'd0: begin ma = {10'b0, dt_q}; mb = {16'b0, grow_q}; end
					2'd1: begin ma = {18'b0, mix_q}; mb = {18'b0, decay_q}; end
					default: begin ma = {10'b0, dt_q}; mb = {18'b0, shrink_q}; end
				endcase
			end
			S_MIXT: begin ma = {2'b0, vn_q}; mb = {18'b0, mix_q}; end
			S_MIX1: begin ma = {2'b0, mag32(vi)}; mb = {17'b0, 17'h10000 - {1'b0, mix_q}}; end
			S_MIX2: begin ma = {2'b0, mag32(gi)}; mb = {2'b0, t_q}; end
			S_MIX4: begin ma = {2'b0, mag32(gi)}; mb = {10'b0, dt_q}; end
			S_MIX5: begin ma = {2'b0, mag32(vi)}; mb = {10'b0, dt_q}; end
			S_CL:   begin ma = {2'b0, mag32(dxi)}; mb = {2'b0, max_disp_q}; end
			default: ;
		endcase
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_GN:  begin req.sqrt_go = 1'b1; req.radicand = acc_q; end
			S_VN:  begin req.sqrt_go = (idx_q == 3'd6); req.radicand = acc_q; end
			S_ND:  begin req.sqrt_go = (idx_q == 3'd6); req.radicand = acc_q; end
			S_MIX2: begin
				req.div_go = (sub_q == 2'd1);
				req.dividend = {2'b0, w_q};
				req.divisor = gn_q;
			end
			S_CL: begin
				req.div_go = (sub_q == 2'd1);
				req.dividend = {2'b0, w_q};
				req.divisor = nd_q;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < 6; i++) m_axis_tdata[32*i +: 32] = dx_q[i];
		m_axis_tdata[223:192] = rms_q;
		m_axis_tdata[234:224] = run_q;
	end
	assign m_axis_tuser = status_q;

	logic [31:0] prod16;
	assign prod16 = mp[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [41:0] sv;
		if (!arst_n) begin
			state_q <= S_IDLE;
			rms_target_q <= 32'd66; start_dt_q <= 24'd6554; max_dt_q <= 24'd65536;
			start_mix_q <= 16'd6554; grow_q <= 18'd72090; shrink_q <= 16'd32768;
			decay_q <= 16'd64881; max_disp_q <= 32'd32768;
			for (int i = 0; i < 6; i++) vel_q[i] <= '0;
			dt_q <= '0; mix_q <= '0; sss_q <= '0; run_q <= '0; vn_q <= '0;
			running_q <= 1'b0; status_q <= '0; idx_q <= '0; sub_q <= '0;
			bit_q <= '0; start_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (fms_pkg::reg_idx_t'(cfg_addr))
					fms_pkg::REG_RMS_TARGET: rms_target_q <= cfg_data;
					fms_pkg::REG_START_DT:   start_dt_q <= cfg_data[23:0];
					fms_pkg::REG_MAX_DT:     max_dt_q <= cfg_data[23:0];
					fms_pkg::REG_START_MIX:  start_mix_q <= cfg_data[15:0];
					fms_pkg::REG_GROW:       grow_q <= cfg_data[17:0];
					fms_pkg::REG_SHRINK:     shrink_q <= cfg_data[15:0];
					fms_pkg::REG_MIX_DECAY:  decay_q <= cfg_data[15:0];
					fms_pkg::REG_MAX_DISP:   max_disp_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					for (int i = 0; i < 6; i++) begin
						g_q[i] <= s_axis_tdata[32*i +: 32];
						dx_q[i] <= '0;
					end
					start_q <= s_axis_tuser;
					acc_q <= '0; idx_q <= '0; state_q <= S_SQ;
				end
				S_SQ: begin
					acc_q <= acc_q + mp;
					if (idx_q == 3'd5) state_q <= S_GN;
					else idx_q <= idx_q + 3'd1;
				end
				S_GN: begin
					// gradient norm runs in the sqrt unit while the rms search uses the multiplier
					rms_q <= '0; bit_q <= 5'd31;
					state_q <= S_RMS;
				end
				S_RMS: begin
					if (six_sq <= acc_q) rms_q <= cand;
					if (bit_q == 5'd0) state_q <= S_RMS_W;
					else bit_q <= bit_q - 5'd1;
				end
				S_RMS_W: if (!rsp.busy) begin
					gn_q <= rsp.root;
					if (start_q) begin
						for (int i = 0; i < 6; i++) vel_q[i] <= '0;
						vn_q <= '0; dt_q <= start_dt_q; mix_q <= start_mix_q;
						sss_q <= '0; run_q <= '0; running_q <= 1'b1;
						state_q <= S_MIXT; sub_q <= 2'd0;
						idx_q <= '0;
					end else if (running_q) begin
						acc_q <= '0; neg_q <= '0; idx_q <= '0; state_q <= S_PW;
					end else begin
						status_q <= (rms_q <= rms_target_q) ?
							fms_pkg::ST_CONVERGED : fms_pkg::ST_LIMIT;
						state_q <= S_OUT;
					end
				end
				S_DECIDE: begin
					if (sub_q == 2'd0) begin
						dt_q <= ({8'b0, mp[39:16]} > {8'b0, max_dt_q} || mp[49:40] != '0) ?
							max_dt_q : mp[39:16];
						sub_q <= 2'd1;
					end else if (sub_q == 2'd1) begin
						mix_q <= mp[31:16];
						acc_q <= '0; idx_q <= '0; state_q <= S_VN;
					end else begin
						dt_q <= mp[39:16];
						mix_q <= start_mix_q; sss_q <= '0;
						for (int i = 0; i < 6; i++) vel_q[i] <= '0;
						vn_q <= '0;
						state_q <= S_MIXT; idx_q <= '0;
					end
				end
				S_PW: begin
					if (vi[31] == gi[31]) acc_q <= acc_q + mp;
					else neg_q <= neg_q + mp;
					if (idx_q == 3'd5) state_q <= S_PW_D;
					else idx_q <= idx_q + 3'd1;
				end
				S_PW_D: begin
					if (acc_q <= neg_q) begin
						if (sss_q > 16'(fms_pkg::MinGrowSteps)) begin
							sub_q <= 2'd0; state_q <= S_DECIDE;
						end else begin
							acc_q <= '0; idx_q <= '0; state_q <= S_VN;
						end
					end else begin
						sub_q <= 2'd2; state_q <= S_DECIDE;
					end
				end
				S_VN: begin
					if (idx_q == 3'd6) state_q <= S_VN_W;
					else begin
						acc_q <= acc_q + mp; idx_q <= idx_q + 3'd1;
					end
				end
				S_VN_W: if (!rsp.busy) begin
					vn_q <= (rsp.root[33:32] != '0) ? 32'hffffffff : rsp.root[31:0];
					state_q <= S_MIXT;
				end
				S_MIXT: begin
					t_q <= mp[47:16];
					idx_q <= '0; sub_q <= '0;
					if (run_q >= 11'(fms_pkg::MaxSteps)) begin
						status_q <= fms_pkg::ST_LIMIT; running_q <= 1'b0; state_q <= S_OUT;
					end else if (rms_q <= rms_target_q) begin
						status_q <= fms_pkg::ST_CONVERGED; running_q <= 1'b0; state_q <= S_OUT;
					end else begin
						status_q <= fms_pkg::ST_CONTINUE;
						if (sss_q != 16'hffff) sss_q <= sss_q + 16'd1;
						run_q <= run_q + 11'd1;
						state_q <= S_MIX1;
					end
				end
				S_MIX1: begin
					sv = vi[31] ? -$signed({10'b0, prod16}) : $signed({10'b0, prod16});
					vel_q[idx_q] <= sv[31:0];
					state_q <= S_MIX2; sub_q <= 2'd0;
				end
				S_MIX2: begin
					if (sub_q == 2'd0) begin
						w_q <= mp[63:0];
						if (gn_q == '0) begin
							t_q <= t_q; state_q <= S_MIX4;
							dx_q[idx_q] <= '0;
						end else sub_q <= 2'd1;
					end else if (sub_q == 2'd1) sub_q <= 2'd2;
					else if (!rsp.busy) begin
						sv = $signed({{10{vel_q[idx_q][31]}}, vel_q[idx_q]}) -
							(gi[31] ? -$signed({8'b0, rsp.quot[33:0]})
							: $signed({8'b0, rsp.quot[33:0]}));
						vel_q[idx_q] <= sat32(sv);
						state_q <= S_MIX4;
					end
				end
				S_MIX4: begin
					sv = $signed({{10{vi[31]}}, vi}) -
						(gi[31] ? -$signed({2'b0, mp[55:16]}) : $signed({2'b0, mp[55:16]}));
					vel_q[idx_q] <= sat32(sv);
					state_q <= S_MIX5;
				end
				S_MIX5: begin
					sv = vi[31] ? -$signed({2'b0, mp[55:16]}) : $signed({2'b0, mp[55:16]});
					dx_q[idx_q] <= sat32(sv);
					if (idx_q == 3'd5) begin
						idx_q <= '0; acc_q <= '0; state_q <= S_ND;
					end else begin
						idx_q <= idx_q + 3'd1; state_q <= S_MIX1;
					end
				end
				S_ND: begin
					if (idx_q == 3'd6) state_q <= S_ND_W;
					else begin
						acc_q <= acc_q + mp; idx_q <= idx_q + 3'd1;
					end
				end
				S_ND_W: if (!rsp.busy) begin
					nd_q <= rsp.root;
					idx_q <= '0; sub_q <= '0;
					state_q <= (rsp.root > {2'b0, max_disp_q}) ? S_CL : S_OUT;
				end
				S_CL: begin
					if (sub_q == 2'd0) begin
						w_q <= mp[63:0]; sub_q <= 2'd1;
					end else if (sub_q == 2'd1) sub_q <= 2'd2;
					else if (!rsp.busy) begin
						dx_q[idx_q] <= dxi[31] ? (~rsp.quot[31:0] + 32'd1) : rsp.quot[31:0];
						sub_q <= 2'd0;
						if (idx_q == 3'd5) state_q <= S_OUT;
						else idx_q <= idx_q + 3'd1;
					end
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/sv/fms_checker.sv
`timescale 1ns / 1ps
module fms_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tready,
	input  logic [191:0]  s_axis_tdata,
	input  logic          s_axis_tuser,
	input  logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  logic [239:0]  m_axis_tdata,
	input  logic [1:0]    m_axis_tuser,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_data,
	output int            fail_count,
	output int            pending,
	output int            moves_seen,
	output int            converged_seen,
	output int            limit_seen
);
	typedef struct packed {
		logic [191:0] disp;
		logic [31:0]  rms;
		logic [1:0]   stat;
		logic [10:0]  steps;
	} step_result_t;

	step_result_t step_q[$];

	// register mirror
	logic [31:0] rms_target;
	logic [23:0] start_dt;
	logic [23:0] max_dt;
	logic [15:0] start_mix;
	logic [17:0] grow;
	logic [15:0] shrink;
	logic [15:0] mix_decay;
	logic [31:0] max_disp;

	// minimiser state
	longint          vel[6];
	longint unsigned dt, mix, since_shrink, run_steps, vel_norm;
	bit              running;

	function automatic longint unsigned magn(longint x);
		return x < 0 ? longint'(0) - x : x;
	endfunction

	function automatic longint signed_as(longint s, longint unsigned m);
		return s < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// product with a q.16 factor, truncated toward zero
	function automatic longint scale_q16(longint a, longint unsigned f);
		return signed_as(a, (magn(a) * f) >> 16);
	endfunction

	function automatic bit [127:0] sq_sum(longint x[6]);
		bit [127:0] s;
		bit [127:0] m;
		s = '0;
		for (int i = 0; i < 6; i++) begin
			m = magn(x[i]);
			s += m * m;
		end
		return s;
	endfunction

	function automatic longint unsigned root(bit [127:0] s);
		longint unsigned r;
		bit [127:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	// floor(sqrt(s / 6))
	function automatic longint unsigned rms_root(bit [127:0] s);
		longint unsigned r;
		bit [127:0] c;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c * 6 <= s) r = c;
		end
		return r;
	endfunction

	function automatic step_result_t fire_step(logic [191:0] d, bit start);
		longint g[6];
		longint dx[6];
		bit [127:0] sg, pos, neg, p;
		longint unsigned rms, gnorm, t, nd, vn;
		logic [1:0] st;
		step_result_t r;
		for (int i = 0; i < 6; i++) begin
			g[i] = longint'($signed(d[32*i +: 32]));
			dx[i] = 0;
		end
		sg = sq_sum(g);
		rms = rms_root(sg);
		gnorm = root(sg);
		st = fms_pkg::ST_CONTINUE;
		if (start) begin
			for (int i = 0; i < 6; i++) vel[i] = 0;
			vel_norm = 0;
			dt = start_dt;
			mix = start_mix;
			since_shrink = 0;
			run_steps = 0;
			running = 1;
		end else if (running) begin
			// power of the previous move, split by sign to stay exact
			pos = '0;
			neg = '0;
			for (int i = 0; i < 6; i++) begin
				p = magn(vel[i]);
				p = p * magn(g[i]);
				if ((vel[i] < 0) == (g[i] < 0)) pos += p;
				else neg += p;
			end
			if (pos <= neg) begin
				if (since_shrink > fms_pkg::MinGrowSteps) begin
					dt = (dt * grow) >> 16;
					if (dt > max_dt) dt = max_dt;
					mix = (mix * mix_decay) >> 16;
				end
				vn = root(sq_sum(vel));
				vel_norm = vn > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : vn;
			end else begin
				dt = (dt * shrink) >> 16;
				mix = start_mix;
				since_shrink = 0;
				for (int i = 0; i < 6; i++) vel[i] = 0;
				vel_norm = 0;
			end
		end

		if (!running) begin
			st = rms <= rms_target ? fms_pkg::ST_CONVERGED : fms_pkg::ST_LIMIT;
		end else if (run_steps >= fms_pkg::MaxSteps) begin
			st = fms_pkg::ST_LIMIT;
			running = 0;
		end else if (rms <= rms_target) begin
			st = fms_pkg::ST_CONVERGED;
			running = 0;
		end else begin
			t = (vel_norm * mix) >> 16;
			if (since_shrink < 65535) since_shrink++;
			run_steps++;
			for (int i = 0; i < 6; i++) begin
				longint keep, term;
				keep = scale_q16(vel[i], 65536 - mix);
				term = gnorm != 0 ? signed_as(g[i], magn(g[i]) * t / gnorm) : 0;
				vel[i] = clamp32(keep - term);
				vel[i] = clamp32(vel[i] - scale_q16(g[i], dt));
				dx[i] = clamp32(scale_q16(vel[i], dt));
			end
			nd = root(sq_sum(dx));
			if (nd > max_disp)
				for (int i = 0; i < 6; i++)
					dx[i] = signed_as(dx[i], magn(dx[i]) * max_disp / nd);
		end

		for (int i = 0; i < 6; i++) r.disp[32*i +: 32] = dx[i][31:0];
		r.rms = rms[31:0];
		r.stat = st;
		r.steps = run_steps[10:0];
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			rms_target = 32'd66;
			start_dt = 24'd6554;
			max_dt = 24'd65536;
			start_mix = 16'd6554;
			grow = 18'd72090;
			shrink = 16'd32768;
			mix_decay = 16'd64881;
			max_disp = 32'd32768;
			for (int i = 0; i < 6; i++) vel[i] = 0;
			dt = 0;
			mix = 0;
			since_shrink = 0;
			run_steps = 0;
			vel_norm = 0;
			running = 0;
			step_q.delete();
			fail_count = 0;
			pending = 0;
			moves_seen = 0;
			converged_seen = 0;
			limit_seen = 0;
		end else begin
			if (cfg_we) begin
				case (fms_pkg::reg_idx_t'(cfg_addr))
					fms_pkg::REG_RMS_TARGET: rms_target = cfg_data;
					fms_pkg::REG_START_DT:   start_dt = cfg_data[23:0];
					fms_pkg::REG_MAX_DT:     max_dt = cfg_data[23:0];
					fms_pkg::REG_START_MIX:  start_mix = cfg_data[15:0];
					fms_pkg::REG_GROW:       grow = cfg_data[17:0];
					fms_pkg::REG_SHRINK:     shrink = cfg_data[15:0];
					fms_pkg::REG_MIX_DECAY:  mix_decay = cfg_data[15:0];
					fms_pkg::REG_MAX_DISP:   max_disp = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				step_q.push_back(fire_step(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (step_q.size() == 0) begin
					report("unexpected beat", m_axis_tdata[63:0], '0);
				end else begin
					want = step_q.pop_front();
					for (int i = 0; i < 6; i++)
						if (m_axis_tdata[32*i +: 32] !== want.disp[32*i +: 32])
							report($sformatf("disp_%0d", i), m_axis_tdata[32*i +: 32],
								want.disp[32*i +: 32]);
					if (m_axis_tdata[223:192] !== want.rms)
						report("rms_value", m_axis_tdata[223:192], want.rms);
					if (m_axis_tdata[234:224] !== want.steps)
						report("steps_taken", m_axis_tdata[234:224], want.steps);
					if (m_axis_tuser !== want.stat)
						report("status", m_axis_tuser, want.stat);
					case (fms_pkg::status_t'(want.stat))
						fms_pkg::ST_CONTINUE:  moves_seen++;
						fms_pkg::ST_CONVERGED: converged_seen++;
						default:               limit_seen++;
					endcase
				end
			end
			pending = step_q.size();
		end
	end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	localparam int IdleLimit = 6000;
	localparam int HoldCycles = 400;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [191:0]  s_axis_tdata;
	logic          s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [239:0]  m_axis_tdata;
	logic [1:0]    m_axis_tuser;
	logic          cfg_we;
	logic [2:0]    cfg_addr;
	logic [31:0]   cfg_data;

	int  fail_count, pending, moves_seen, converged_seen, limit_seen;
	int  idle_cycles;
	int  beats_sent;
	bit  eager;
	bit  hold_req;

	fire_minimizer_step_top i_dut (.*);

	fms_checker i_checker (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("watchdog expired, %0d results outstanding", pending);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result side
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 0;
			end
			gap = eager ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic cfg_write(fms_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_regs(logic [31:0] tgt, logic [31:0] sdt, logic [31:0] mdt,
			logic [31:0] smix, logic [31:0] gr, logic [31:0] sh, logic [31:0] dec,
			logic [31:0] mdisp);
		cfg_write(fms_pkg::REG_RMS_TARGET, tgt);
		cfg_write(fms_pkg::REG_START_DT, sdt);
		cfg_write(fms_pkg::REG_MAX_DT, mdt);
		cfg_write(fms_pkg::REG_START_MIX, smix);
		cfg_write(fms_pkg::REG_GROW, gr);
		cfg_write(fms_pkg::REG_SHRINK, sh);
		cfg_write(fms_pkg::REG_MIX_DECAY, dec);
		cfg_write(fms_pkg::REG_MAX_DISP, mdisp);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_beat(logic [191:0] grad, bit start);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= grad;
		s_axis_tuser <= start;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
		gap = eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] small_val(int lo_bits, int hi_bits);
		logic [31:0] m;
		m = $urandom() & ((32'd1 << $urandom_range(lo_bits, hi_bits)) - 1);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [191:0] fill_grad(logic [31:0] v);
		return {6{v}};
	endfunction

	function automatic logic [191:0] wild_grad();
		logic [191:0] g;
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(0, 4))
				0: g[32*i +: 32] = 32'h8000_0000;
				1: g[32*i +: 32] = 32'h7FFF_FFFF;
				2: g[32*i +: 32] = '0;
				default: g[32*i +: 32] = $urandom();
			endcase
		end
		return g;
	endfunction

	// a run with a drifting downhill direction, uphill kicks now and then
	task automatic minimise_run(int len, int mag_bits);
		logic [31:0] base[6];
		logic [191:0] g;
		for (int i = 0; i < 6; i++) base[i] = small_val(4, mag_bits);
		for (int i = 0; i < 6; i++) g[32*i +: 32] = base[i];
		send_beat(g, 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0)
				for (int i = 0; i < 6; i++) base[i] = -base[i];
			if ($urandom_range(0, 3) == 0)
				for (int i = 0; i < 6; i++) base[i] = $signed(base[i]) >>> 1;
			for (int i = 0; i < 6; i++)
				g[32*i +: 32] = base[i] + small_val(0, mag_bits > 6 ? mag_bits - 4 : 2);
			send_beat(g, 0);
		end
	endtask

	task automatic random_phase(int beats);
		int sent_here;
		sent_here = 0;
		while (sent_here < beats) begin
			if ($urandom_range(0, 9) == 0) eager = !eager;
			if ($urandom_range(0, 4) == 0) begin
				send_beat($urandom_range(0, 1) ? wild_grad()
					: {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom()}, $urandom_range(0, 1));
				sent_here++;
			end else begin
				int len;
				len = $urandom_range(2, 25);
				minimise_run(len, $urandom_range(6, 30));
				sent_here += len + 1;
			end
		end
		eager = 0;
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_data = '0;
		eager = 0;
		hold_req = 0;
		beats_sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, reset register values
		send_beat('0, 0);                            // idle, converged
		send_beat(fill_grad(32'h0001_0000), 0);      // idle, not converged
		send_beat('0, 1);                            // start at the minimum
		send_beat(fill_grad(32'h8000_0000), 1);
		send_beat(fill_grad(32'h8000_0000), 0);
		send_beat(fill_grad(32'h7FFF_FFFF), 1);
		send_beat(fill_grad(32'h7FFF_FFFF), 0);
		send_beat({32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
			32'h8000_0000}, 1);
		send_beat(fill_grad(32'h0002_0000), 1);
		for (int k = 0; k < 8; k++) send_beat(fill_grad(32'h0002_0000), 0);
		send_beat(fill_grad(32'hFFFE_0000), 0);      // uphill, shrink
		send_beat(fill_grad(32'h0001_0000), 0);
		send_beat(fill_grad(32'h0001_0000), 1);      // restart while running
		send_beat('0, 0);                            // zero gradient converges
		wait_drained();

		// upper extremes of every register
		load_regs(32'hFFFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF, 32'h3FFFF,
			32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
		random_phase(20);
		wait_drained();
		load_regs(32'd0, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF, 32'h3FFFF, 32'hFFFF,
			32'hFFFF, 32'hFFFF_FFFF);
		random_phase(60);
		wait_drained();

		// lower extremes
		load_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		random_phase(40);
		wait_drained();

		// mid-range settings with a long stall on the result side
		load_regs(32'd1 << $urandom_range(4, 14), $urandom_range(1000, 30000),
			$urandom_range(40000, 200000), $urandom(), $urandom_range(65536, 100000),
			$urandom(), $urandom_range(50000, 65535), $urandom_range(1000, 1 << 20));
		random_phase(40);
		hold_req = 1;
		for (int k = 0; k < 6; k++) send_beat(fill_grad(32'h0003_0000), k == 0);
		random_phase(100);
		wait_drained();

		load_regs(32'd1 << $urandom_range(0, 20), $urandom_range(0, 24'hFF_FFFF),
			$urandom_range(0, 24'hFF_FFFF), $urandom(), $urandom_range(0, 18'h3FFFF),
			$urandom(), $urandom(), $urandom());
		random_phase(140);
		@(negedge clk);
		s_axis_tvalid <= 0;

		do @(posedge clk); while (pending != 0);
		repeat (800) @(posedge clk);
		$display("%0d gradient beats sent over several register settings", beats_sent);
		$display("results: %0d moves, %0d converged, %0d stopped or at step limit",
			moves_seen, converged_seen, limit_seen);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/fms_pkg.sv
rtl/fms_iter.sv
rtl/fire_minimizer_step_top.sv
tb/sv/fms_checker.sv
tb/sv/tb_top.sv
